### rtl/gsm7_pkg.sv
// Shared types, constants and character tables for the GSM 7-bit to UTF-8 decoder.
// No dependencies; every other file imports this package.
package gsm7_pkg;

  // Input item: one packed byte and the start-of-message marker.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_req;
  } gsm7_in_t;

  // Output item: one UTF-8 byte and the end-of-item marker.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } gsm7_out_t;

  // Configuration register values.
  typedef struct packed {
    logic [2:0] pad_bits;
    logic [7:0] septet_count;
  } gsm7_cfg_t;

  // Register indexes on the configuration port.
  localparam logic CFG_PAD_BITS     = 1'b0;
  localparam logic CFG_SEPTET_COUNT = 1'b1;

  localparam logic [6:0] SEPTET_ESC = 7'h1B;

  typedef logic [15:0] gsm7_cp_t;

  // Characters decoded from one packed byte: up to three code points.
  typedef struct packed {
    gsm7_cp_t [2:0] cp;
    logic [1:0]     chars;
  } gsm7_grp_t;

  localparam gsm7_cp_t BASE_ROM [128] = '{
    16'h0040, 16'h00A3, 16'h0024, 16'h00A5, 16'h00E8, 16'h00E9, 16'h00F9, 16'h00EC,
    16'h00F2, 16'h00C7, 16'h000A, 16'h00D8, 16'h00F8, 16'h000D, 16'h00C5, 16'h00E5,
    16'h0394, 16'h005F, 16'h03A6, 16'h0393, 16'h039B, 16'h03A9, 16'h03A0, 16'h03A8,
    16'h03A3, 16'h0398, 16'h039E, 16'h0020, 16'h00C6, 16'h00E6, 16'h00DF, 16'h00C9,
    16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'h00A4, 16'h0025, 16'h0026, 16'h0027,
    16'h0028, 16'h0029, 16'h002A, 16'h002B, 16'h002C, 16'h002D, 16'h002E, 16'h002F,
    16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
    16'h0038, 16'h0039, 16'h003A, 16'h003B, 16'h003C, 16'h003D, 16'h003E, 16'h003F,
    16'h00A1, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
    16'h0048, 16'h0049, 16'h004A, 16'h004B, 16'h004C, 16'h004D, 16'h004E, 16'h004F,
    16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
    16'h0058, 16'h0059, 16'h005A, 16'h00C4, 16'h00D6, 16'h00D1, 16'h00DC, 16'h00A7,
    16'h00BF, 16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067,
    16'h0068, 16'h0069, 16'h006A, 16'h006B, 16'h006C, 16'h006D, 16'h006E, 16'h006F,
    16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075, 16'h0076, 16'h0077,
    16'h0078, 16'h0079, 16'h007A, 16'h00E4, 16'h00F6, 16'h00F1, 16'h00FC, 16'h00E0
  };

  // Extension table; unmapped codes give a space.
  function automatic gsm7_cp_t ext_map(logic [6:0] s);
    gsm7_cp_t cp;
    unique case (s)
      7'h0A:   cp = 16'h000A;
      7'h14:   cp = 16'h005E;
      7'h28:   cp = 16'h007B;
      7'h29:   cp = 16'h007D;
      7'h2F:   cp = 16'h005C;
      7'h3C:   cp = 16'h005B;
      7'h3D:   cp = 16'h007E;
      7'h3E:   cp = 16'h005D;
      7'h40:   cp = 16'h007C;
      7'h65:   cp = 16'h20AC;
      default: cp = 16'h0020;
    endcase
    return cp;
  endfunction

  // Number of UTF-8 bytes for a code point below 0x10000.
  function automatic logic [1:0] utf8_len(gsm7_cp_t cp);
    logic [1:0] len;
    if (cp <= 16'h007F) begin
      len = 2'd1;
    end else if (cp <= 16'h07FF) begin
      len = 2'd2;
    end else begin
      len = 2'd3;
    end
    return len;
  endfunction

endpackage

### rtl/gsm7_front.sv
// Front end: accepts packed bytes, unpacks septets and maps them to code points.
// Depends on gsm7_pkg.
module gsm7_front import gsm7_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  gsm7_cfg_t cfg_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  gsm7_in_t  in_data_i,
  input  logic      q_full_i,
  output logic      push_o,
  output gsm7_grp_t push_grp_o
);

  logic [13:0] store_q, store_d;
  logic [3:0]  held_q, held_d;
  logic        esc_q, esc_d;
  logic [7:0]  done_q, done_d;
  logic        first_q, first_d;

  logic        accept;
  logic        clr;
  logic [13:0] store0;
  logic [3:0]  held0;
  logic        esc0;
  logic [7:0]  done0;
  logic        first0;
  logic        active;
  logic [7:0]  sh_byte;
  logic [3:0]  byte_bits;
  logic [22:0] cat_store;
  logic [4:0]  cat_held;
  logic [7:0]  avail;
  logic [1:0]  nsep_h;
  logic [1:0]  nsep;
  logic [6:0]  sept;
  logic        esc_w;
  logic [1:0]  n_w;
  gsm7_grp_t   grp;
  logic [22:0] store_n;
  logic [4:0]  held_n;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  // Start request clears the message state ahead of this byte.
  assign clr    = in_data_i.start_req;
  assign store0 = clr ? '0 : store_q;
  assign held0  = clr ? '0 : held_q;
  assign esc0   = clr ? 1'b0 : esc_q;
  assign done0  = clr ? '0 : done_q;
  assign first0 = clr ? 1'b1 : first_q;
  assign active = done0 < cfg_i.septet_count;

  assign sh_byte   = first0 ? (in_data_i.in_byte >> cfg_i.pad_bits) : in_data_i.in_byte;
  assign byte_bits = first0 ? (4'd8 - {1'b0, cfg_i.pad_bits}) : 4'd8;
  assign cat_store = {9'd0, store0} | ({15'd0, sh_byte} << held0);
  assign cat_held  = {1'b0, held0} + {1'b0, byte_bits};
  assign avail     = cfg_i.septet_count - done0;

  always_comb begin
    if (cat_held >= 5'd21) begin
      nsep_h = 2'd3;
    end else if (cat_held >= 5'd14) begin
      nsep_h = 2'd2;
    end else if (cat_held >= 5'd7) begin
      nsep_h = 2'd1;
    end else begin
      nsep_h = 2'd0;
    end
    nsep = (avail < {6'd0, nsep_h}) ? avail[1:0] : nsep_h;
  end

  // Walk the septets of this byte in order; escapes emit nothing.
  always_comb begin
    esc_w     = esc0;
    n_w       = '0;
    grp       = '0;
    sept      = '0;
    for (int k = 0; k < 3; k++) begin
      sept = cat_store[7*k +: 7];
      if (2'(k) < nsep) begin
        if (sept == SEPTET_ESC) begin
          esc_w = 1'b1;
        end else begin
          grp.cp[n_w] = esc_w ? ext_map(sept) : BASE_ROM[sept];
          esc_w       = 1'b0;
          n_w         = n_w + 2'd1;
        end
      end
    end
    grp.chars = n_w;
  end

  always_comb begin
    unique case (nsep)
      2'd0: begin store_n = cat_store;         held_n = cat_held;         end
      2'd1: begin store_n = cat_store >> 7;    held_n = cat_held - 5'd7;  end
      2'd2: begin store_n = cat_store >> 14;   held_n = cat_held - 5'd14; end
      2'd3: begin store_n = cat_store >> 21;   held_n = cat_held - 5'd21; end
      default: begin store_n = cat_store;      held_n = cat_held;         end
    endcase
  end

  always_comb begin
    store_d = store_q;
    held_d  = held_q;
    esc_d   = esc_q;
    done_d  = done_q;
    first_d = first_q;
    if (accept) begin
      if (active) begin
        store_d = store_n[13:0];
        held_d  = held_n[3:0];
        esc_d   = esc_w;
        done_d  = done0 + {6'd0, nsep};
        first_d = 1'b0;
      end else if (clr) begin
        store_d = '0;
        held_d  = '0;
        esc_d   = 1'b0;
        done_d  = '0;
        first_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q <= '0;
      held_q  <= '0;
      esc_q   <= 1'b0;
      done_q  <= '0;
      first_q <= 1'b1;
    end else begin
      store_q <= store_d;
      held_q  <= held_d;
      esc_q   <= esc_d;
      done_q  <= done_d;
      first_q <= first_d;
    end
  end

  assign push_o     = accept && active && (n_w != 2'd0);
  assign push_grp_o = grp;

endmodule

### rtl/gsm7_queue.sv
// Short register queue of decoded character groups between front and back end.
// Depends on gsm7_pkg.
module gsm7_queue import gsm7_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  gsm7_grp_t push_grp_i,
  output logic      full_o,
  output logic      head_valid_o,
  output gsm7_grp_t head_o,
  input  logic      pop_i
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  gsm7_grp_t       mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o       = cnt_q == CntW'(Depth);
  assign head_valid_o = cnt_q != '0;
  assign head_o       = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_grp_i;
    end
  end

endmodule

### rtl/gsm7_back.sv
// Back end: turns queued code points into UTF-8 bytes, one per cycle unless stalled.
// Depends on gsm7_pkg.
module gsm7_back import gsm7_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      head_valid_i,
  input  gsm7_grp_t head_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output gsm7_out_t out_data_o
);

  logic [1:0] ci_q;
  logic [1:0] bi_q;
  logic       out_valid_q;
  gsm7_out_t  out_q;

  gsm7_cp_t   cp_sel;
  logic [1:0] len;
  logic [7:0] byte_w;
  logic       char_end;
  logic       grp_end;
  logic       load;

  assign cp_sel   = head_i.cp[ci_q];
  assign len      = utf8_len(cp_sel);
  assign char_end = bi_q == (len - 2'd1);
  assign grp_end  = ci_q == (head_i.chars - 2'd1);
  assign load     = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o    = load && char_end && grp_end;

  always_comb begin
    priority if (len == 2'd1) begin
      byte_w = cp_sel[7:0];
    end else if (len == 2'd2) begin
      byte_w = (bi_q == 2'd0) ? {3'b110, cp_sel[10:6]} : {2'b10, cp_sel[5:0]};
    end else if (bi_q == 2'd0) begin
      byte_w = {4'b1110, cp_sel[15:12]};
    end else if (bi_q == 2'd1) begin
      byte_w = {2'b10, cp_sel[11:6]};
    end else begin
      byte_w = {2'b10, cp_sel[5:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ci_q        <= '0;
      bi_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        if (char_end) begin
          bi_q <= '0;
          ci_q <= grp_end ? 2'd0 : ci_q + 2'd1;
        end else begin
          bi_q <= bi_q + 2'd1;
        end
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.out_byte <= byte_w;
      out_q.last     <= char_end && grp_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/gsm7_packed_to_utf8_decoder.sv
// Top level of the GSM 7-bit packed text to UTF-8 decoder.
// Depends on gsm7_pkg, gsm7_front, gsm7_queue and gsm7_back.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   in_data_i  (gsm7_in_t)
//   out      output     out_valid_o / out_stall_i out_data_o (gsm7_out_t)
//   cfg      input      cfg_we_i                  cfg_idx_i, cfg_data_i
//
// The front end takes one byte per cycle while the queue has room. The back end sends
// one UTF-8 byte per cycle while the output is not stalled; an input item yields 0 to 6
// UTF-8 bytes, up to 9 after the septet count is raised over a stopped message. The
// first byte of an item passes through the queue and then the output register.
// Reset clears the control state and sets both configuration registers to zero.
// in_stall_o rises only when the queue is full; out_stall_i holds the output register.
module gsm7_packed_to_utf8_decoder import gsm7_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  gsm7_in_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output gsm7_out_t  out_data_o
);

  gsm7_cfg_t cfg_q;

  logic      push;
  gsm7_grp_t push_grp;
  logic      q_full;
  logic      head_valid;
  gsm7_grp_t head;
  logic      pop;

  // Configuration registers; the user must write them only while the block is idle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PAD_BITS:     cfg_q.pad_bits     <= cfg_data_i[2:0];
        CFG_SEPTET_COUNT: cfg_q.septet_count <= cfg_data_i;
        default:          cfg_q              <= cfg_q;
      endcase
    end
  end

  // Unpack and map: one byte in, up to three characters into the queue.
  gsm7_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_grp_o (push_grp)
  );

  // Decouple the bursty back end from the byte stream.
  gsm7_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_grp_i   (push_grp),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  // Serialize each character into its UTF-8 bytes; mark the final one of the item.
  gsm7_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

### rtl/gsm7_checker.sv
// Port-level checks for the GSM 7-bit to UTF-8 decoder, bound to the top level.
// Depends on gsm7_pkg and gsm7_packed_to_utf8_decoder.
module gsm7_checker import gsm7_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input gsm7_in_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input gsm7_out_t out_data_o
);

  // Hold a stalled input item.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled input changed");

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output changed");

  // A lead byte of a multi-byte character never closes an item.
  a_lead_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.out_byte[7:5] == 3'b110 ||
                    out_data_o.out_byte[7:4] == 4'b1110) |-> !out_data_o.last)
    else $error("lead byte marked last");

  // Only code points below 0x10000 and no overlong two-byte leads.
  a_byte_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.out_byte[7:4] != 4'hF &&
                    out_data_o.out_byte[7:1] != 7'h60)
    else $error("invalid UTF-8 byte");

  // After a two-byte lead byte is taken, the next result, if valid, continues it.
  a_cont_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_data_o.out_byte[7:5] == 3'b110
      |=> !out_valid_o || out_data_o.out_byte[7:6] == 2'b10)
    else $error("continuation byte missing");

endmodule

bind gsm7_packed_to_utf8_decoder gsm7_checker u_gsm7_checker (.*);

### tb/tb.sv
// Self-checking testbench for gsm7_packed_to_utf8_decoder: packed GSM 7-bit bytes go in,
// UTF-8 bytes come out and are compared against an in-bench decoder model.
// Depends on gsm7_pkg and the decoder RTL only.
`timescale 1ns / 100ps

module tb;
  import gsm7_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned RANDOM_BYTES = 460;
  // Longest random message; a larger septet count leaves the message open.
  localparam int unsigned MSG_SEPTETS_MAX = 32;
  // Cycles to let the queue and serializer settle once nothing more is expected.
  localparam int unsigned SETTLE_CYCLES = 30;

  // GSM 03.38 default alphabet, septet to code point.
  localparam bit [15:0] GSM_DEFAULT [128] = '{
    16'h0040, 16'h00A3, 16'h0024, 16'h00A5, 16'h00E8, 16'h00E9, 16'h00F9, 16'h00EC,
    16'h00F2, 16'h00C7, 16'h000A, 16'h00D8, 16'h00F8, 16'h000D, 16'h00C5, 16'h00E5,
    16'h0394, 16'h005F, 16'h03A6, 16'h0393, 16'h039B, 16'h03A9, 16'h03A0, 16'h03A8,
    16'h03A3, 16'h0398, 16'h039E, 16'h0020, 16'h00C6, 16'h00E6, 16'h00DF, 16'h00C9,
    16'h0020, 16'h0021, 16'h0022, 16'h0023, 16'h00A4, 16'h0025, 16'h0026, 16'h0027,
    16'h0028, 16'h0029, 16'h002A, 16'h002B, 16'h002C, 16'h002D, 16'h002E, 16'h002F,
    16'h0030, 16'h0031, 16'h0032, 16'h0033, 16'h0034, 16'h0035, 16'h0036, 16'h0037,
    16'h0038, 16'h0039, 16'h003A, 16'h003B, 16'h003C, 16'h003D, 16'h003E, 16'h003F,
    16'h00A1, 16'h0041, 16'h0042, 16'h0043, 16'h0044, 16'h0045, 16'h0046, 16'h0047,
    16'h0048, 16'h0049, 16'h004A, 16'h004B, 16'h004C, 16'h004D, 16'h004E, 16'h004F,
    16'h0050, 16'h0051, 16'h0052, 16'h0053, 16'h0054, 16'h0055, 16'h0056, 16'h0057,
    16'h0058, 16'h0059, 16'h005A, 16'h00C4, 16'h00D6, 16'h00D1, 16'h00DC, 16'h00A7,
    16'h00BF, 16'h0061, 16'h0062, 16'h0063, 16'h0064, 16'h0065, 16'h0066, 16'h0067,
    16'h0068, 16'h0069, 16'h006A, 16'h006B, 16'h006C, 16'h006D, 16'h006E, 16'h006F,
    16'h0070, 16'h0071, 16'h0072, 16'h0073, 16'h0074, 16'h0075, 16'h0076, 16'h0077,
    16'h0078, 16'h0079, 16'h007A, 16'h00E4, 16'h00F6, 16'h00F1, 16'h00FC, 16'h00E0
  };

  // Septets worth putting behind an escape: every extension entry, one more escape
  // (repeated escape), and a code without an entry (decodes to a space).
  localparam bit [6:0] ESC_FOLLOWERS [12] = '{
    7'h0A, 7'h14, 7'h28, 7'h29, 7'h2F, 7'h3C, 7'h3D, 7'h3E, 7'h40, 7'h65,
    SEPTET_ESC, 7'h41
  };

  // Decoder model plus the queue of UTF-8 bytes it still owes.
  class utf8_checker;
    bit [2:0]  pad_bits;
    bit [7:0]  septet_count;
    bit [13:0] bit_store;
    bit [3:0]  bits_held;
    bit        escape_armed;
    bit [7:0]  septets_done;
    bit        first_byte;
    gsm7_out_t utf8_pending[$];
    int        errors;

    function new();
      restart_message();
    endfunction

    function void restart_message();
      bit_store    = '0;
      bits_held    = '0;
      escape_armed = 1'b0;
      septets_done = '0;
      first_byte   = 1'b1;
    endfunction

    function void set_register(logic idx, bit [7:0] value);
      if (idx == CFG_PAD_BITS) begin
        pad_bits = value[2:0];
      end else begin
        septet_count = value;
      end
    endfunction

    function bit [15:0] escape_char(bit [6:0] s);
      case (s)
        7'h0A:   return 16'h000A;
        7'h14:   return 16'h005E;
        7'h28:   return 16'h007B;
        7'h29:   return 16'h007D;
        7'h2F:   return 16'h005C;
        7'h3C:   return 16'h005B;
        7'h3D:   return 16'h007E;
        7'h3E:   return 16'h005D;
        7'h40:   return 16'h007C;
        7'h65:   return 16'h20AC;
        default: return 16'h0020;
      endcase
    endfunction

    function void push_utf8(bit [15:0] cp);
      gsm7_out_t o;
      o.last = 1'b0;
      if (cp <= 16'h007F) begin
        o.out_byte = cp[7:0];
        utf8_pending.push_back(o);
      end else if (cp <= 16'h07FF) begin
        o.out_byte = {3'b110, cp[10:6]};
        utf8_pending.push_back(o);
        o.out_byte = {2'b10, cp[5:0]};
        utf8_pending.push_back(o);
      end else begin
        o.out_byte = {4'b1110, cp[15:12]};
        utf8_pending.push_back(o);
        o.out_byte = {2'b10, cp[11:6]};
        utf8_pending.push_back(o);
        o.out_byte = {2'b10, cp[5:0]};
        utf8_pending.push_back(o);
      end
    endfunction

    // Decode one accepted byte; returns 0 when the block has to ignore it.
    function bit take_packed_byte(gsm7_in_t it);
      bit [31:0]   window;
      int unsigned avail;
      bit [6:0]    sym;
      bit [15:0]   cp;
      int          old_size;
      gsm7_out_t   tail;
      if (it.start_req) restart_message();
      if (septets_done >= septet_count) return 1'b0;
      old_size = utf8_pending.size();
      if (first_byte) begin
        window     = 32'(it.in_byte) >> pad_bits;
        avail      = 8 - pad_bits;
        first_byte = 1'b0;
      end else begin
        window = 32'(it.in_byte);
        avail  = 8;
      end
      window = (window << bits_held) | 32'(bit_store);
      avail += bits_held;
      while (avail >= 7 && septets_done < septet_count) begin
        sym    = window[6:0];
        window = window >> 7;
        avail -= 7;
        septets_done++;
        if (sym == SEPTET_ESC) begin
          escape_armed = 1'b1;
        end else begin
          if (escape_armed) begin
            cp           = escape_char(sym);
            escape_armed = 1'b0;
          end else begin
            cp = GSM_DEFAULT[sym];
          end
          push_utf8(cp);
        end
      end
      bit_store = window[13:0];
      bits_held = avail[3:0];
      if (utf8_pending.size() > old_size) begin
        tail      = utf8_pending.pop_back();
        tail.last = 1'b1;
        utf8_pending.push_back(tail);
      end
      return 1'b1;
    endfunction

    function void check_utf8_byte(gsm7_out_t got);
      gsm7_out_t want;
      if (utf8_pending.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected UTF-8 byte %02h last %0b", got.out_byte, got.last);
        end
        return;
      end
      want = utf8_pending.pop_front();
      if (got.out_byte !== want.out_byte || got.last !== want.last) begin
        errors++;
        if (errors <= 10) begin
          $display("UTF-8 mismatch: expected byte %02h last %0b, got byte %02h last %0b",
                   want.out_byte, want.last, got.out_byte, got.last);
        end
      end
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      cfg_we_i;
  logic      cfg_idx_i;
  logic [7:0] cfg_data_i;
  logic      in_valid_i;
  logic      in_stall_o;
  gsm7_in_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  gsm7_out_t out_data_o;

  utf8_checker chk;
  bit          no_gaps;     // set for phases that run both sides flat out
  int unsigned used_bytes;  // bytes that actually fed the decoder
  int unsigned cycle_count;

  gsm7_packed_to_utf8_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Hard stop in case a handshake hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Idle cycles before the next item on either side.
  function automatic int draw_wait();
    return no_gaps ? 0 : $urandom_range(0, 10);
  endfunction

  // Check every UTF-8 byte taken at this edge; values read here are the pre-edge ones.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) chk.check_utf8_byte(out_data_o);
  end

  // Output side: stall a random number of cycles, then take one item.
  initial begin : utf8_sink
    int hold;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      hold = draw_wait();
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Write one register; only called while the block is idle.
  task automatic write_reg(input logic idx, input bit [7:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    chk.set_register(idx, value);
  endtask

  // Offer one packed byte and hold it until taken. Valid stays high afterwards so a
  // back-to-back item needs no second assignment in the same step.
  task automatic send_packed(input bit [7:0] b, input bit start);
    int       gap;
    gsm7_in_t it;
    gap          = draw_wait();
    it.in_byte   = b;
    it.start_req = start;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    if (chk.take_packed_byte(it)) used_bytes++;
  endtask

  // Pack septets LSB first behind pad fill bits, then send all but the last drop bytes.
  // Fill and trailing bits are random.
  task automatic send_message(input bit [6:0] sq[$], input int unsigned pad,
                              input int unsigned drop);
    bit [7:0] bq[$];
    bit [7:0] acc;
    int       pos;
    acc = 8'($urandom);
    pos = pad;
    foreach (sq[k]) begin
      for (int j = 0; j < 7; j++) begin
        acc[pos] = sq[k][j];
        pos++;
        if (pos == 8) begin
          bq.push_back(acc);
          acc = 8'($urandom);
          pos = 0;
        end
      end
    end
    if (pos > 0) bq.push_back(acc);
    for (int k = 0; k + drop < bq.size(); k++) send_packed(bq[k], k == 0);
  endtask

  // Hold the sender until every expected byte is out, then let the block settle.
  task automatic drain_outputs();
    in_valid_i <= 1'b0;
    while (chk.utf8_pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    bit [6:0]    msg[$];
    bit [2:0]    pad;
    bit [7:0]    count;
    int          kind;
    int          nmsg;
    int          nbytes;
    int unsigned msg_len;
    chk        = new();
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_PAD_BITS;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    no_gaps    = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Out of reset the septet count is zero: the byte must be dropped.
    send_packed(8'hA5, 1'b1);
    drain_outputs();

    // Alphabet ends, euro sign, repeated escape, unmapped escape, two-byte Greek,
    // currency sign, newline, escaped brace, and an escape left armed at the end.
    write_reg(CFG_PAD_BITS, 8'h00);
    write_reg(CFG_SEPTET_COUNT, 8'd16);
    msg = '{7'h00, 7'h7F, SEPTET_ESC, 7'h65, SEPTET_ESC, SEPTET_ESC, 7'h14, SEPTET_ESC,
            7'h41, 7'h10, 7'h24, 7'h0A, SEPTET_ESC, 7'h28, 7'h20, SEPTET_ESC};
    send_message(msg, 0, 0);
    send_packed(8'hFF, 1'b0);  // message complete: drop it
    drain_outputs();

    // Pad of seven, written with the unused data bits set.
    write_reg(CFG_PAD_BITS, 8'hFF);
    write_reg(CFG_SEPTET_COUNT, 8'd3);
    msg = '{7'h7F, SEPTET_ESC, 7'h3C};
    send_message(msg, 7, 0);
    drain_outputs();

    // Lower the count below what is done: drop; then raise it and resume the stopped
    // message from its leftover bits.
    write_reg(CFG_SEPTET_COUNT, 8'd1);
    send_packed(8'h00, 1'b0);
    drain_outputs();
    write_reg(CFG_PAD_BITS, 8'h06);
    write_reg(CFG_SEPTET_COUNT, 8'd255);
    send_packed(8'h00, 1'b0);
    send_packed(8'hFF, 1'b0);
    send_packed(8'hC0, 1'b1);
    send_packed(8'h55, 1'b0);
    drain_outputs();

    // Random phases: new settings each phase, mostly well-formed messages. A large
    // count keeps messages short and leaves them open for the next start.
    used_bytes = 0;
    while (used_bytes < RANDOM_BYTES) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      pad     = 3'($urandom);
      case ($urandom_range(0, 11))
        0:       count = 8'd255;
        1:       count = 8'd0;
        default: count = 8'($urandom_range(1, 24));
      endcase
      write_reg(CFG_PAD_BITS, {5'($urandom), pad});
      write_reg(CFG_SEPTET_COUNT, count);
      msg_len = (count > MSG_SEPTETS_MAX) ? MSG_SEPTETS_MAX : count;
      nmsg = $urandom_range(1, 4);
      for (int m = 0; m < nmsg; m++) begin
        kind = $urandom_range(0, 7);
        if (kind == 0 || count == 0) begin
          // Raw bytes, mostly without a start: continue or disturb a message.
          nbytes = $urandom_range(1, 5);
          repeat (nbytes) send_packed(8'($urandom), $urandom_range(0, 3) == 0);
        end else begin
          msg.delete();
          while (msg.size() < msg_len) begin
            if ($urandom_range(0, 5) == 0) begin
              msg.push_back(SEPTET_ESC);
              msg.push_back($urandom_range(0, 1) ? ESC_FOLLOWERS[$urandom_range(0, 11)]
                                                 : 7'($urandom));
            end else begin
              msg.push_back(7'($urandom));
            end
          end
          while (msg.size() > msg_len) void'(msg.pop_back());
          // Kind 1 cuts the message short; kind 2 sends one byte past its end.
          send_message(msg, pad, (kind == 1) ? $urandom_range(1, 3) : 0);
          if (kind == 2) send_packed(8'($urandom), 1'b0);
        end
      end
      drain_outputs();
    end

    if (chk.errors == 0 && chk.utf8_pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### gsm7_packed_to_utf8_decoder.f
rtl/gsm7_pkg.sv
rtl/gsm7_front.sv
rtl/gsm7_queue.sv
rtl/gsm7_back.sv
rtl/gsm7_packed_to_utf8_decoder.sv
rtl/gsm7_checker.sv
tb/tb.sv
